// ----- rtl/core/spba_pkg.sv -----
// shared types and constants of the speed priority bus arbiter
package spba_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W    = 6;
    localparam int SIZE_W  = 24;
    localparam int SPEED_W = 30;
    localparam int TIME_W  = 32;
    localparam int ACQ_W   = 10;
    localparam int USEC_W  = 20;
    localparam int NUM_W   = SIZE_W + USEC_W;

    localparam logic [USEC_W-1:0] USEC_PER_SEC  = USEC_W'(1000000);
    localparam logic [ACQ_W-1:0]  ACQUIRE_RESET = ACQ_W'(20);
    localparam logic [TIME_W-1:0] TIME_MAX      = '1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_SERVICE = 1'b1;
    localparam logic EV_RELEASE   = 1'b0;
    localparam logic EV_GRANT     = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]    proc_id;
        logic [SIZE_W-1:0]  io_size;
        logic [SPEED_W-1:0] speed;
        logic [TIME_W-1:0]  now;
    } t_in_req;

    typedef struct packed {
        logic              event_res;
        logic [ID_W-1:0]   who;
        logic [TIME_W-1:0] busy_until;
        logic              last;
    } t_out_res;

    typedef struct packed {
        logic [ID_W-1:0]    proc_id;
        logic [SIZE_W-1:0]  io_size;
        logic [SPEED_W-1:0] speed;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   push;
        logic   pick;
        t_entry entry;
    } t_q_cmd;

    typedef struct packed {
        logic [Q_CW-1:0] count;
        logic            busy;
        logic            done;
        t_entry          pick;
    } t_q_stat;

endpackage

// ----- rtl/core/spba_ram.sv -----
// generic single write port ram with registered read
module spba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/spba_endcalc.sv -----
// busy-until unit: constant multiply, serial ceiling divide, add and saturate
module spba_endcalc
    import spba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic [SPEED_W-1:0] i_speed,
    input  logic [TIME_W-1:0]  i_now,
    input  logic [ACQ_W-1:0]   i_acq,
    output logic               o_done,
    output logic [TIME_W-1:0]  o_busy_until
);

    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [1:0] {E_IDLE, E_MUL, E_DIV, E_SUM} t_state;

    t_state             r_state;
    logic [NUM_W-1:0]   r_nq;
    logic [SPEED_W-1:0] r_rem;
    logic [STEP_W-1:0]  r_step;
    logic               r_done;
    logic [TIME_W-1:0]  r_result;

    logic [NUM_W-1:0]   prod;
    logic [SPEED_W:0]   rem_sh;
    logic [SPEED_W:0]   rem_sub;
    logic               ge;
    logic [TIME_W+1:0]  sum;
    logic               sat;

    always_comb begin
        prod    = NUM_W'(i_size) * NUM_W'(USEC_PER_SEC);
        rem_sh  = {r_rem, r_nq[NUM_W-1]};
        ge      = rem_sh >= {1'b0, i_speed};
        rem_sub = rem_sh - {1'b0, i_speed};
        // quotient plus one when the division leaves a remainder
        sum     = (TIME_W+2)'(r_nq[TIME_W-1:0]) + (TIME_W+2)'(i_now)
                + (TIME_W+2)'(i_acq) + (TIME_W+2)'(r_rem != '0);
        sat     = (|r_nq[NUM_W-1:TIME_W]) || (|sum[TIME_W+1:TIME_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        if (i_speed == '0) begin
                            r_result <= TIME_MAX;
                            r_done   <= 1'b1;
                        end else begin
                            r_state <= E_MUL;
                        end
                    end
                end
                E_MUL: begin
                    r_nq    <= prod;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= E_DIV;
                end
                E_DIV: begin
                    r_rem  <= ge ? rem_sub[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
                    r_nq   <= {r_nq[NUM_W-2:0], ge};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(NUM_W - 1)) begin
                        r_state <= E_SUM;
                    end
                end
                E_SUM: begin
                    r_result <= sat ? TIME_MAX : sum[TIME_W-1:0];
                    r_done   <= 1'b1;
                    r_state  <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_busy_until = r_result;

endmodule

// ----- rtl/core/spba_queue.sv -----
// waiting queue: append, priority scan and compaction over one ram
module spba_queue
    import spba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_cmd  i_cmd,
    output t_q_stat o_stat
);

    typedef enum logic [1:0] {Q_IDLE, Q_SCAN, Q_SHIFT} t_state;

    t_state          r_state;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] r_ptr;
    logic            r_rv;
    logic [Q_AW-1:0] r_ridx;
    logic [Q_AW-1:0] r_best_idx;
    t_entry          r_best;
    logic            r_done;

    logic               full;
    logic               ram_we;
    logic [Q_AW-1:0]    ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;

    assign full     = r_count == Q_CW'(QUEUE_DEPTH);
    assign rd_entry = t_entry'(ram_rdata);

    always_comb begin
        if (r_state == Q_SHIFT) begin
            // move each later entry down by one
            ram_we    = r_rv;
            ram_waddr = r_ridx - Q_AW'(1);
            ram_wdata = ram_rdata;
        end else begin
            ram_we    = (r_state == Q_IDLE) && i_cmd.push && !full;
            ram_waddr = r_count[Q_AW-1:0];
            ram_wdata = i_cmd.entry;
        end
    end

    spba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[Q_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                Q_IDLE: begin
                    if (i_cmd.push && !full) begin
                        r_count <= r_count + Q_CW'(1);
                    end
                    if (i_cmd.pick) begin
                        r_state <= Q_SCAN;
                        r_ptr   <= '0;
                        r_rv    <= 1'b0;
                    end
                end
                Q_SCAN: begin
                    if (r_ptr < r_count) begin
                        r_ptr  <= r_ptr + Q_CW'(1);
                        r_rv   <= 1'b1;
                        r_ridx <= r_ptr[Q_AW-1:0];
                    end else begin
                        r_rv <= 1'b0;
                    end
                    // strictly faster wins, so the earliest stays on ties
                    if (r_rv && (r_ridx == '0 || rd_entry.speed > r_best.speed)) begin
                        r_best     <= rd_entry;
                        r_best_idx <= r_ridx;
                    end
                    if (r_ptr == r_count && !r_rv) begin
                        r_state <= Q_SHIFT;
                        r_ptr   <= Q_CW'(r_best_idx) + Q_CW'(1);
                    end
                end
                Q_SHIFT: begin
                    if (r_ptr < r_count) begin
                        r_ptr  <= r_ptr + Q_CW'(1);
                        r_rv   <= 1'b1;
                        r_ridx <= r_ptr[Q_AW-1:0];
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_ptr == r_count && !r_rv) begin
                        r_count <= r_count - Q_CW'(1);
                        r_done  <= 1'b1;
                        r_state <= Q_IDLE;
                    end
                end
                default: r_state <= Q_IDLE;
            endcase
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.busy  = r_state != Q_IDLE;
    assign o_stat.done  = r_done;
    assign o_stat.pick  = r_best;

endmodule

// ----- rtl/core/speed_priority_bus_arbiter.sv -----
// top level of the speed priority bus arbiter with its grant sequencer
//
// input channel (i_in_valid / o_in_ready, payload i_in_req):
//   kind request queues {proc_id, io_size, speed} in arrival order; a request
//   that finds the queue full is dropped. kind service carries the time now.
// output channel (o_out_valid / i_out_ready, payload o_out_res): a service
//   yields nothing, a release, a grant, or a release then a grant; last marks
//   the final one. a request yields nothing.
// config channel (i_cfg_valid / o_cfg_ready, i_cfg_acquire_time): always
//   ready, sets the overhead added to every grant.
// timing: one request per cycle is taken while idle. a service that only
//   releases skips the queue and the busy-until unit. a grant runs the queue
//   scan, the compaction and the busy-until unit (start, one multiply, 44
//   divide steps, one add) in that order before the grant is offered.
// a finished result waits in one output register; the block goes back to
//   idle and takes new requests while it waits, and a service that needs the
//   register again holds until the receiver takes the pending one.
// reset: queue empty, no holder, acquire time 20; the queue ram needs no clear
module speed_priority_bus_arbiter
    import spba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_req          i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_res         o_out_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [ACQ_W-1:0] i_cfg_acquire_time
);

    typedef enum logic [2:0] {S_IDLE, S_REL, S_PICK, S_CALC, S_GRANT} t_state;

    t_state            r_state;
    logic [ACQ_W-1:0]  r_acq;
    logic              r_holder_valid;
    logic [ID_W-1:0]   r_holder_id;
    logic [TIME_W-1:0] r_holder_end;
    logic [TIME_W-1:0] r_now;
    logic              r_grant_next;
    t_entry            r_pick;
    logic              r_pick_go;
    logic              r_calc_go;
    logic [TIME_W-1:0] r_busy;
    logic              r_out_valid;
    t_out_res          r_out;

    t_q_cmd            q_cmd;
    t_q_stat           q_stat;
    logic              calc_done;
    logic [TIME_W-1:0] calc_busy;

    logic              in_acc;
    logic              out_free;
    logic              rel_now;
    logic              grant_now;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // release when the holder's time is up, grant when the bus ends up free and the queue is not empty
    assign rel_now   = r_holder_valid && (i_in_req.now >= r_holder_end);
    assign grant_now = (!r_holder_valid || rel_now) && (q_stat.count != '0);

    assign q_cmd.push  = in_acc && (i_in_req.kind == KIND_REQUEST);
    assign q_cmd.pick  = r_pick_go;
    assign q_cmd.entry = '{proc_id: i_in_req.proc_id,
                           io_size: i_in_req.io_size,
                           speed:   i_in_req.speed};

    spba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    spba_endcalc u_endcalc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_calc_go),
        .i_size       (r_pick.io_size),
        .i_speed      (r_pick.speed),
        .i_now        (r_now),
        .i_acq        (r_acq),
        .o_done       (calc_done),
        .o_busy_until (calc_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_acq          <= ACQUIRE_RESET;
            r_holder_valid <= 1'b0;
            r_holder_id    <= '0;
            r_holder_end   <= '0;
            r_pick_go      <= 1'b0;
            r_calc_go      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_pick_go <= 1'b0;
            r_calc_go <= 1'b0;
            if (i_cfg_valid) begin
                r_acq <= i_cfg_acquire_time;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_req.kind == KIND_SERVICE) begin
                        r_now        <= i_in_req.now;
                        r_grant_next <= grant_now;
                        if (rel_now) begin
                            r_state <= S_REL;
                        end else if (grant_now) begin
                            r_state   <= S_PICK;
                            r_pick_go <= 1'b1;
                        end
                    end
                end
                S_REL: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out          <= '{event_res:  EV_RELEASE,
                                            who:        r_holder_id,
                                            busy_until: '0,
                                            last:       !r_grant_next};
                        r_holder_valid <= 1'b0;
                        if (r_grant_next) begin
                            r_state   <= S_PICK;
                            r_pick_go <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PICK: begin
                    if (q_stat.done) begin
                        r_pick    <= q_stat.pick;
                        r_calc_go <= 1'b1;
                        r_state   <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (calc_done) begin
                        r_busy  <= calc_busy;
                        r_state <= S_GRANT;
                    end
                end
                S_GRANT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out          <= '{event_res:  EV_GRANT,
                                            who:        r_pick.proc_id,
                                            busy_until: r_busy,
                                            last:       1'b1};
                        r_holder_valid <= 1'b1;
                        r_holder_id    <= r_pick.proc_id;
                        r_holder_end   <= r_busy;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // queue must be quiet whenever new requests are taken
    a_queue_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !q_stat.busy)
        else $error("queue busy while input ready");

    // a pending grant always belongs to a live holder
    a_grant_has_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_GRANT) |-> r_holder_valid)
        else $error("grant pending without holder");

    // fill count never passes the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CW'(QUEUE_DEPTH))
        else $error("queue count overflow");

    // a pick only starts with something waiting
    a_pick_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pick_go |-> (q_stat.count != '0 && r_state == S_PICK))
        else $error("pick started on empty queue");

    // the busy-until unit only finishes while the sequencer waits for it
    a_calc_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        calc_done |-> r_state == S_CALC)
        else $error("busy-until result outside calc state");

endmodule

// ----- verif/spba_scoreboard_pkg.sv -----
// scoreboard class that predicts the bus grants and releases and checks them
`timescale 1ns / 100ps

package spba_scoreboard_pkg;
    import spba_pkg::*;

    class bus_grant_scoreboard;
        t_entry            waiting_q[$];
        logic              holder_valid;
        logic [ID_W-1:0]   holder_id;
        logic [TIME_W-1:0] holder_end;
        logic [ACQ_W-1:0]  acquire_time;
        t_out_res          expected_q[$];
        int unsigned       error_count;

        function new();
            holder_valid = 1'b0;
            holder_id    = '0;
            holder_end   = '0;
            acquire_time = ACQUIRE_RESET;
            error_count  = 0;
        endfunction

        function void set_acquire(logic [ACQ_W-1:0] value);
            acquire_time = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // now + overhead + ceil(size * 1e6 / speed), clipped at the top of the time range
        function logic [TIME_W-1:0] transfer_end(logic [TIME_W-1:0] now, t_entry e);
            logic [63:0] xfer;
            logic [63:0] total;
            if (e.speed == '0) return TIME_MAX;
            xfer  = (64'(e.io_size) * 64'(USEC_PER_SEC) + 64'(e.speed) - 64'd1) / 64'(e.speed);
            total = 64'(now) + 64'(acquire_time) + xfer;
            return (total > 64'(TIME_MAX)) ? TIME_MAX : total[TIME_W-1:0];
        endfunction

        // returns 0 only for a request dropped on a full queue
        function bit note_item(t_in_req item);
            bit              rel_due;
            bit              grant_due;
            logic [ID_W-1:0] rel_id;
            int              best;
            t_entry          pick;
            if (item.kind == KIND_REQUEST) begin
                if (waiting_q.size() >= QUEUE_DEPTH) return 1'b0;
                waiting_q.push_back(t_entry'{item.proc_id, item.io_size, item.speed});
                return 1'b1;
            end
            rel_id  = '0;
            rel_due = holder_valid && (item.now >= holder_end);
            if (rel_due) begin
                rel_id       = holder_id;
                holder_valid = 1'b0;
            end
            grant_due = !holder_valid && (waiting_q.size() != 0);
            if (grant_due) begin
                // fastest wins, strict compare keeps the earliest on a tie
                best = 0;
                for (int i = 1; i < waiting_q.size(); i++) begin
                    if (waiting_q[i].speed > waiting_q[best].speed) best = i;
                end
                pick = waiting_q[best];
                waiting_q.delete(best);
                holder_valid = 1'b1;
                holder_id    = pick.proc_id;
                holder_end   = transfer_end(item.now, pick);
            end
            if (rel_due)
                expected_q.push_back(t_out_res'{EV_RELEASE, rel_id, TIME_W'(0), !grant_due});
            if (grant_due)
                expected_q.push_back(t_out_res'{EV_GRANT, holder_id, holder_end, 1'b1});
            return 1'b1;
        endfunction

        function void check_field(string field, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                error_count++;
            end
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: event_res %0d who %0d busy_until %0d last %0d",
                       got.event_res, got.who, got.busy_until, got.last);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            check_field("event_res", TIME_W'(want.event_res), TIME_W'(got.event_res));
            check_field("who", TIME_W'(want.who), TIME_W'(got.who));
            check_field("busy_until", want.busy_until, got.busy_until);
            check_field("last", TIME_W'(want.last), TIME_W'(got.last));
        endfunction
    endclass

endpackage

// ----- verif/speed_priority_bus_arbiter_test.sv -----
// top level testbench of the speed priority bus arbiter
`timescale 1ns / 100ps

module speed_priority_bus_arbiter_test;
    import spba_pkg::*;
    import spba_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 2000000;
    // room for the longest grant with a full queue, plus a pending result
    localparam int unsigned SETTLE_CYCLES = 400;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    t_in_req          in_req      = '0;
    logic             out_ready   = 1'b0;
    logic             cfg_valid   = 1'b0;
    logic [ACQ_W-1:0] cfg_acquire = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_cfg_ready;
    t_out_res         o_out_res;

    int unsigned       cycle_count = 0;
    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_idle_pct = 0;
    int unsigned       live_items  = 0;
    logic [TIME_W-1:0] base_now    = '0;

    bus_grant_scoreboard sb = new();

    speed_priority_bus_arbiter i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_in_req           (in_req),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_out_res          (o_out_res),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_acquire_time (cfg_acquire)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake ends the run here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // result side: check what is taken at this edge, then pick ready for the next one
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) sb.check_result(o_out_res);
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // request item; the fields a request ignores still carry random bits
    function automatic t_in_req req_item(logic [ID_W-1:0] id, logic [SIZE_W-1:0] size,
                                         logic [SPEED_W-1:0] spd);
        t_in_req r;
        r.kind    = KIND_REQUEST;
        r.proc_id = id;
        r.io_size = size;
        r.speed   = spd;
        r.now     = $urandom;
        return r;
    endfunction

    function automatic t_in_req svc_item(logic [TIME_W-1:0] now);
        t_in_req r;
        r.kind    = KIND_SERVICE;
        r.proc_id = ID_W'($urandom);
        r.io_size = SIZE_W'($urandom);
        r.speed   = SPEED_W'($urandom);
        r.now     = now;
        return r;
    endfunction

    // mostly small transfers on fast devices, with ties and the odd slow or huge one
    function automatic t_in_req make_request();
        logic [SPEED_W-1:0] spd;
        logic [SIZE_W-1:0]  size;
        int unsigned        roll;
        roll = $urandom_range(99);
        if (roll < 25) begin
            case ($urandom_range(2))
                0:       spd = SPEED_W'(1000);
                1:       spd = SPEED_W'(1000000);
                default: spd = SPEED_W'(1000000000);
            endcase
        end else if (roll < 85) begin
            spd = SPEED_W'($urandom_range(100000, 1000000000));
        end else if (roll < 95) begin
            spd = SPEED_W'($urandom);
        end else begin
            spd = SPEED_W'($urandom_range(0, 3));
        end
        size = ($urandom_range(9) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 4095));
        return req_item(ID_W'($urandom), size, spd);
    endfunction

    // service times track the predicted holder end so that releases actually happen
    function automatic t_in_req make_service();
        logic [TIME_W-1:0] t;
        logic [TIME_W:0]   wide;
        int unsigned       roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            t = $urandom;
        end else if (sb.holder_valid && roll < 75) begin
            // at or just past the end, clipped at the top of the range
            wide = {1'b0, sb.holder_end} + (TIME_W+1)'($urandom_range(0, 40));
            t    = wide[TIME_W] ? TIME_MAX : wide[TIME_W-1:0];
        end else if (sb.holder_valid && sb.holder_end != '0) begin
            // still busy: just short of the end
            t = (sb.holder_end > 500) ? sb.holder_end - TIME_W'($urandom_range(1, 500))
                                      : sb.holder_end - 1;
        end else begin
            t = base_now + TIME_W'($urandom_range(0, 2000));
        end
        base_now = t;
        return svc_item(t);
    endfunction

    function automatic t_in_req make_noise();
        t_in_req r;
        r.kind    = 1'($urandom);
        r.proc_id = ID_W'($urandom);
        r.io_size = SIZE_W'($urandom);
        r.speed   = SPEED_W'($urandom);
        r.now     = $urandom;
        return r;
    endfunction

    // one item on the input channel, with an optional gap in front of it
    task automatic send_item(t_in_req item);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_req   <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        if (sb.note_item(item)) live_items++;
    endtask

    // hold the sender until every predicted result has been taken
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // acquire time changes only with the block idle
    task automatic write_acquire(logic [ACQ_W-1:0] value);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_acquire <= value;
        cfg_valid   <= 1'b1;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        sb.set_acquire(value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // zero speed, ties and saturation, with the reset acquire time
    task automatic run_directed();
        send_item(svc_item('0));                                  // nothing to do
        send_item(req_item(6'd1, SIZE_W'(100), SPEED_W'(1000000)));
        send_item(req_item(6'd2, SIZE_W'(200), SPEED_W'(1000000))); // tie with id 1
        send_item(req_item(6'd3, '1, '0));                        // zero speed
        send_item(req_item(6'd0, '1, '1));                        // largest size and speed
        send_item(req_item(6'd63, '0, SPEED_W'(1)));              // empty transfer
        send_item(svc_item('0));                                  // grant the fastest
        send_item(svc_item(TIME_W'(5)));                          // still busy
        send_item(svc_item(TIME_MAX));                            // release, earliest of tie
        send_item(svc_item(TIME_MAX));
        send_item(svc_item(TIME_MAX));
        send_item(svc_item(TIME_MAX));                            // zero speed granted last
        send_item(svc_item(TIME_MAX));                            // release only
        send_item(svc_item(TIME_MAX));                            // idle bus
        send_item(req_item(6'd10, SIZE_W'(1), SPEED_W'(1000000000)));
        send_item(svc_item(TIME_W'(100)));                        // ends at 121
        send_item(svc_item(TIME_W'(121)));                        // release exactly at end
        send_item(req_item(6'd42, '1, SPEED_W'(1)));              // transfer time overflows
        send_item(svc_item('0));
        send_item(svc_item(TIME_MAX - 1));                        // one short of the end
        send_item(svc_item(TIME_MAX));
    endtask

    // mostly request / service traffic, rare queue floods, some fully random items
    task automatic run_random(int unsigned count);
        int unsigned goal;
        int unsigned roll;
        goal = live_items + count;
        while (live_items < goal) begin
            roll = $urandom_range(999);
            if (sb.waiting_q.size() > 12 && roll < 280) roll += 280;
            if (roll == 0) begin
                repeat (QUEUE_DEPTH + 6) send_item(make_request());
            end else if (roll < 280) begin
                repeat ($urandom_range(1, 2)) send_item(make_request());
            end else if (roll < 850) begin
                send_item(make_service());
            end else begin
                send_item(make_noise());
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles often, receiver stalls half the time
        tx_idle_pct  = 27;
        rx_idle_pct <= 50;
        run_directed();
        write_acquire('0);
        run_random(350);
        wait_results();
        run_random(350);

        // the other way round
        write_acquire('1);
        tx_idle_pct  = 50;
        rx_idle_pct <= 27;
        run_random(650);

        // back to back on both sides
        write_acquire(ACQ_W'($urandom));
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        run_random(650);

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
